// ----- rtl/bsf_pkg.sv -----
package bsf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int GYRO_BITS_DEF = 10;

    localparam int GAIN_W     = 32;
    localparam int ENC_W      = 32;
    localparam int TILT_W     = 40;
    localparam int TILT_LO_W  = 20;
    localparam int TILT_HI_W  = TILT_W - TILT_LO_W;
    localparam int ACC_W      = 74;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SPEED_W    = 8;
    localparam int SPEED_LIMIT = 100;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TILT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VELOCITY = 3'd4;

    localparam int GYRO_OFFSET_RST = 595;
    localparam logic signed [GAIN_W-1:0] GAIN_TILT_RST     = 32'sd8071;
    localparam logic signed [GAIN_W-1:0] GAIN_RATE_RST     = 32'sd159966;
    localparam logic signed [GAIN_W-1:0] GAIN_POSITION_RST = 32'sd35247;
    localparam logic signed [GAIN_W-1:0] GAIN_VELOCITY_RST = 32'sd6593576;

    typedef struct packed {
        logic signed [GAIN_W-1:0] tilt;
        logic signed [GAIN_W-1:0] rate;
        logic signed [GAIN_W-1:0] position;
        logic signed [GAIN_W-1:0] velocity;
    } bsf_gains_t;

endpackage

// ----- rtl/bsf_if.sv -----
interface bsf_sample_if
    import bsf_pkg::*;
#(
    parameter int GYRO_BITS = GYRO_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [GYRO_BITS-1:0]    gyro_sample;
    logic signed [ENC_W-1:0] encoder_count;

    modport source (output valid, output gyro_sample, output encoder_count, input ready);
    modport sink   (input valid, input gyro_sample, input encoder_count, output ready);
endinterface

interface bsf_command_if
    import bsf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_percent;
    logic                      clamped;

    modport source (output valid, output speed_percent, output clamped, input ready);
    modport sink   (input valid, input speed_percent, input clamped, output ready);
endinterface

interface bsf_cfg_if
    import bsf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bsf_state.sv -----
module bsf_state
    import bsf_pkg::*;
#(
    parameter int GYRO_BITS = GYRO_BITS_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [GYRO_BITS-1:0]     gyro_sample,
    input  logic signed [ENC_W-1:0]  encoder_count,
    output bsf_gains_t               gains,
    output logic                     op_valid,
    input  logic                     op_ready,
    output logic signed [TILT_W-1:0] op_tilt,
    output logic signed [GYRO_BITS:0] op_rate,
    output logic signed [ENC_W-1:0]  op_position,
    output logic signed [ENC_W-1:0]  op_delta
);

    localparam logic signed [TILT_W-1:0] TILT_MAX = {1'b0, {(TILT_W-1){1'b1}}};
    localparam logic signed [TILT_W-1:0] TILT_MIN = {1'b1, {(TILT_W-1){1'b0}}};

    logic [GYRO_BITS-1:0]     gyro_offset_reg;
    bsf_gains_t               gains_reg;
    logic signed [TILT_W-1:0] tilt_sum_reg;
    logic signed [TILT_W-1:0] tilt_sum_next;
    logic signed [ENC_W-1:0]  last_encoder_reg;
    logic signed [ENC_W-1:0]  position_sum_reg;
    logic signed [ENC_W-1:0]  position_sum_next;
    logic signed [GYRO_BITS:0] rate;
    logic signed [TILT_W:0]   tilt_wide;
    logic signed [ENC_W-1:0]  delta;
    logic                     op_valid_reg;
    logic signed [TILT_W-1:0] op_tilt_reg;
    logic signed [GYRO_BITS:0] op_rate_reg;
    logic signed [ENC_W-1:0]  op_position_reg;
    logic signed [ENC_W-1:0]  op_delta_reg;
    logic                     in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !op_valid_reg || op_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        rate = $signed({1'b0, gyro_sample}) - $signed({1'b0, gyro_offset_reg});
        tilt_wide = (TILT_W+1)'(tilt_sum_reg) + (TILT_W+1)'(rate);
        if (tilt_wide[TILT_W] != tilt_wide[TILT_W-1])
        begin
            tilt_sum_next = tilt_wide[TILT_W] ? TILT_MIN : TILT_MAX;
        end
        else
        begin
            tilt_sum_next = tilt_wide[TILT_W-1:0];
        end
        delta = encoder_count - last_encoder_reg;
        position_sum_next = position_sum_reg + delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_offset_reg    <= GYRO_BITS'(GYRO_OFFSET_RST);
            gains_reg.tilt     <= GAIN_TILT_RST;
            gains_reg.rate     <= GAIN_RATE_RST;
            gains_reg.position <= GAIN_POSITION_RST;
            gains_reg.velocity <= GAIN_VELOCITY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GYRO_OFFSET:   gyro_offset_reg    <= cfg_data[GYRO_BITS-1:0];
                REG_GAIN_TILT:     gains_reg.tilt     <= cfg_data;
                REG_GAIN_RATE:     gains_reg.rate     <= cfg_data;
                REG_GAIN_POSITION: gains_reg.position <= cfg_data;
                REG_GAIN_VELOCITY: gains_reg.velocity <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_sum_reg     <= '0;
            last_encoder_reg <= '0;
            position_sum_reg <= '0;
            op_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                tilt_sum_reg     <= tilt_sum_next;
                last_encoder_reg <= encoder_count;
                position_sum_reg <= position_sum_next;
                op_valid_reg     <= 1'b1;
            end
            else if (op_ready)
            begin
                op_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_tilt_reg     <= tilt_sum_next;
            op_rate_reg     <= rate;
            op_position_reg <= position_sum_next;
            op_delta_reg    <= delta;
        end
    end

    assign gains       = gains_reg;
    assign op_valid    = op_valid_reg;
    assign op_tilt     = op_tilt_reg;
    assign op_rate     = op_rate_reg;
    assign op_position = op_position_reg;
    assign op_delta    = op_delta_reg;

endmodule

// ----- rtl/bsf_mult.sv -----
module bsf_mult
    import bsf_pkg::*;
#(
    parameter int GYRO_BITS = GYRO_BITS_DEF
)(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bsf_gains_t                             gains,
    input  logic                                   op_valid,
    output logic                                   op_ready,
    input  logic signed [TILT_W-1:0]               op_tilt,
    input  logic signed [GYRO_BITS:0]              op_rate,
    input  logic signed [ENC_W-1:0]                op_position,
    input  logic signed [ENC_W-1:0]                op_delta,
    output logic                                   prod_valid,
    input  logic                                   prod_ready,
    output logic signed [TILT_HI_W+GAIN_W-1:0]     prod_tilt_hi,
    output logic signed [TILT_LO_W+GAIN_W:0]       prod_tilt_lo,
    output logic signed [GYRO_BITS+GAIN_W:0]       prod_rate,
    output logic signed [ENC_W+GAIN_W-1:0]         prod_position,
    output logic signed [ENC_W+GAIN_W-1:0]         prod_delta
);

    logic signed [TILT_HI_W-1:0]           tilt_hi;
    logic signed [TILT_LO_W:0]             tilt_lo;
    logic                                  prod_valid_reg;
    logic signed [TILT_HI_W+GAIN_W-1:0]    prod_tilt_hi_reg;
    logic signed [TILT_LO_W+GAIN_W:0]      prod_tilt_lo_reg;
    logic signed [GYRO_BITS+GAIN_W:0]      prod_rate_reg;
    logic signed [ENC_W+GAIN_W-1:0]        prod_position_reg;
    logic signed [ENC_W+GAIN_W-1:0]        prod_delta_reg;
    logic                                  op_accept;

    // tilt sum is split so each multiply stays near 32x32
    assign tilt_hi = op_tilt[TILT_W-1:TILT_LO_W];
    assign tilt_lo = $signed({1'b0, op_tilt[TILT_LO_W-1:0]});

    assign op_ready  = !prod_valid_reg || prod_ready;
    assign op_accept = op_valid && op_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (op_accept)
        begin
            prod_valid_reg <= 1'b1;
        end
        else if (prod_ready)
        begin
            prod_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_accept)
        begin
            prod_tilt_hi_reg  <= tilt_hi * gains.tilt;
            prod_tilt_lo_reg  <= tilt_lo * gains.tilt;
            prod_rate_reg     <= op_rate * gains.rate;
            prod_position_reg <= op_position * gains.position;
            prod_delta_reg    <= op_delta * gains.velocity;
        end
    end

    assign prod_valid    = prod_valid_reg;
    assign prod_tilt_hi  = prod_tilt_hi_reg;
    assign prod_tilt_lo  = prod_tilt_lo_reg;
    assign prod_rate     = prod_rate_reg;
    assign prod_position = prod_position_reg;
    assign prod_delta    = prod_delta_reg;

endmodule

// ----- rtl/bsf_out.sv -----
module bsf_out
    import bsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int GYRO_BITS = GYRO_BITS_DEF
)(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   prod_valid,
    output logic                                   prod_ready,
    input  logic signed [TILT_HI_W+GAIN_W-1:0]     prod_tilt_hi,
    input  logic signed [TILT_LO_W+GAIN_W:0]       prod_tilt_lo,
    input  logic signed [GYRO_BITS+GAIN_W:0]       prod_rate,
    input  logic signed [ENC_W+GAIN_W-1:0]         prod_position,
    input  logic signed [ENC_W+GAIN_W-1:0]         prod_delta,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SPEED_W-1:0]              speed_percent,
    output logic                                   clamped
);

    localparam logic signed [ACC_W-1:0] POS_LIMIT = ACC_W'(SPEED_LIMIT);
    localparam logic signed [ACC_W-1:0] NEG_LIMIT = -POS_LIMIT;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(SPEED_LIMIT);
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -SPEED_MAX;

    logic signed [ACC_W-1:0]   tilt_hi_ext;
    logic signed [ACC_W-1:0]   sum_next;
    logic signed [ACC_W-1:0]   sum_reg;
    logic                      sum_valid_reg;
    logic signed [ACC_W-1:0]   floor_q;
    logic signed [ACC_W-1:0]   trunc_q;
    logic                      round_up;
    logic signed [SPEED_W-1:0] speed_next;
    logic                      clamp_next;
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic                      clamped_reg;
    logic                      prod_accept;
    logic                      sum_to_out;

    assign sum_to_out  = sum_valid_reg && (!out_valid_reg || out_ready);
    assign prod_ready  = !sum_valid_reg || sum_to_out;
    assign prod_accept = prod_valid && prod_ready;

    always_comb
    begin
        tilt_hi_ext = ACC_W'(prod_tilt_hi);
        sum_next = (tilt_hi_ext <<< TILT_LO_W) + ACC_W'(prod_tilt_lo) + ACC_W'(prod_rate)
                 + ACC_W'(prod_position) + ACC_W'(prod_delta);
    end

    // truncate toward zero: floor, then bump negatives with a nonzero fraction
    always_comb
    begin
        floor_q  = sum_reg >>> FRAC_BITS;
        round_up = sum_reg[ACC_W-1] && (sum_reg[FRAC_BITS-1:0] != '0);
        trunc_q  = floor_q + $signed({{(ACC_W-1){1'b0}}, round_up});
        if (trunc_q > POS_LIMIT)
        begin
            speed_next = SPEED_MAX;
            clamp_next = 1'b1;
        end
        else if (trunc_q < NEG_LIMIT)
        begin
            speed_next = SPEED_MIN;
            clamp_next = 1'b1;
        end
        else
        begin
            speed_next = trunc_q[SPEED_W-1:0];
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod_accept)
            begin
                sum_valid_reg <= 1'b1;
            end
            else if (sum_to_out)
            begin
                sum_valid_reg <= 1'b0;
            end

            if (sum_to_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_accept)
        begin
            sum_reg <= sum_next;
        end
        if (sum_to_out)
        begin
            speed_reg   <= speed_next;
            clamped_reg <= clamp_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign speed_percent = speed_reg;
    assign clamped       = clamped_reg;

endmodule

// ----- rtl/balance_state_feedback_unit.sv -----
// Balance state feedback for a two-wheel inverted pendulum. Each sample item
// (raw gyro reading, accumulated encoder count) updates the saturating tilt
// sum, the last encoder count and the position sum, and yields one command
// item: the Q(FRAC_BITS) sum of four gain products, truncated toward zero
// and limited to +/-100 percent, with clamped set when the limit applied.
// One item is accepted per clock unless back-pressure stalls it; a command
// is offered through four registered stages (state update, multiply, sum,
// truncate/clamp), each able to fill while a finished command waits
// downstream. Throughput is set by the tilt-sum and encoder update loop.
// Gains and the gyro offset are written through the cfg channel, index 0 to
// 4; other indexes are ignored. Write them only while the block is idle.
module balance_state_feedback_unit
    import bsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int GYRO_BITS = GYRO_BITS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    bsf_cfg_if.sink       cfg,
    bsf_sample_if.sink    sample,
    bsf_command_if.source command
);

    bsf_gains_t                            gains;
    logic                                  op_valid;
    logic                                  op_ready;
    logic signed [TILT_W-1:0]              op_tilt;
    logic signed [GYRO_BITS:0]             op_rate;
    logic signed [ENC_W-1:0]               op_position;
    logic signed [ENC_W-1:0]               op_delta;
    logic                                  prod_valid;
    logic                                  prod_ready;
    logic signed [TILT_HI_W+GAIN_W-1:0]    prod_tilt_hi;
    logic signed [TILT_LO_W+GAIN_W:0]      prod_tilt_lo;
    logic signed [GYRO_BITS+GAIN_W:0]      prod_rate;
    logic signed [ENC_W+GAIN_W-1:0]        prod_position;
    logic signed [ENC_W+GAIN_W-1:0]        prod_delta;

    bsf_state #(
        .GYRO_BITS (GYRO_BITS)
    ) u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .in_valid      (sample.valid),
        .in_ready      (sample.ready),
        .gyro_sample   (sample.gyro_sample),
        .encoder_count (sample.encoder_count),
        .gains         (gains),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op_tilt       (op_tilt),
        .op_rate       (op_rate),
        .op_position   (op_position),
        .op_delta      (op_delta)
    );

    bsf_mult #(
        .GYRO_BITS (GYRO_BITS)
    ) u_mult (
        .clk           (clk),
        .rst_n         (rst_n),
        .gains         (gains),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op_tilt       (op_tilt),
        .op_rate       (op_rate),
        .op_position   (op_position),
        .op_delta      (op_delta),
        .prod_valid    (prod_valid),
        .prod_ready    (prod_ready),
        .prod_tilt_hi  (prod_tilt_hi),
        .prod_tilt_lo  (prod_tilt_lo),
        .prod_rate     (prod_rate),
        .prod_position (prod_position),
        .prod_delta    (prod_delta)
    );

    bsf_out #(
        .FRAC_BITS (FRAC_BITS),
        .GYRO_BITS (GYRO_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .prod_valid    (prod_valid),
        .prod_ready    (prod_ready),
        .prod_tilt_hi  (prod_tilt_hi),
        .prod_tilt_lo  (prod_tilt_lo),
        .prod_rate     (prod_rate),
        .prod_position (prod_position),
        .prod_delta    (prod_delta),
        .out_valid     (command.valid),
        .out_ready     (command.ready),
        .speed_percent (command.speed_percent),
        .clamped       (command.clamped)
    );

endmodule

// ----- tb/balance_state_feedback_unit_tb.sv -----
`timescale 1ns / 1ps

module balance_state_feedback_unit_tb;
    import bsf_pkg::*;

    localparam logic signed [TILT_W:0] TILT_MAX = (41'sd1 <<< (TILT_W - 1)) - 41'sd1;
    localparam logic signed [TILT_W:0] TILT_MIN = -(41'sd1 <<< (TILT_W - 1));
    localparam int ACC_PRED_W = 80;

    typedef struct {
        logic signed [SPEED_W-1:0] speed_percent;
        logic                      clamped;
    } command_t;

    class command_scoreboard;
        logic [GYRO_BITS_DEF-1:0]  gyro_offset;
        logic signed [GAIN_W-1:0]  gain_tilt;
        logic signed [GAIN_W-1:0]  gain_rate;
        logic signed [GAIN_W-1:0]  gain_position;
        logic signed [GAIN_W-1:0]  gain_velocity;
        logic signed [TILT_W-1:0]  tilt_sum;
        logic [ENC_W-1:0]          last_encoder;
        logic [ENC_W-1:0]          position_sum;
        command_t                  expected_cmds[$];
        int                        errors;

        function new();
            gyro_offset   = GYRO_BITS_DEF'(GYRO_OFFSET_RST);
            gain_tilt     = GAIN_TILT_RST;
            gain_rate     = GAIN_RATE_RST;
            gain_position = GAIN_POSITION_RST;
            gain_velocity = GAIN_VELOCITY_RST;
            tilt_sum      = '0;
            last_encoder  = '0;
            position_sum  = '0;
            errors        = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected_cmds.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GYRO_OFFSET:   gyro_offset   = data[GYRO_BITS_DEF-1:0];
                REG_GAIN_TILT:     gain_tilt     = data;
                REG_GAIN_RATE:     gain_rate     = data;
                REG_GAIN_POSITION: gain_position = data;
                REG_GAIN_VELOCITY: gain_velocity = data;
                default: ;
            endcase
        endfunction

        function logic signed [ACC_PRED_W-1:0] mul_wide(logic signed [ACC_PRED_W-1:0] x,
                                                        logic signed [ACC_PRED_W-1:0] y);
            return x * y;
        endfunction

        function void note_sample(logic [GYRO_BITS_DEF-1:0] gyro, logic [ENC_W-1:0] enc);
            logic signed [GYRO_BITS_DEF:0]   rate;
            logic signed [TILT_W:0]          tsum;
            logic [ENC_W-1:0]                delta;
            logic signed [ACC_PRED_W-1:0]    acc;
            logic [ACC_PRED_W-1:0]           mag;
            logic                            neg;
            logic signed [SPEED_W-1:0]       speed;
            command_t                        cmd;
            rate = $signed({1'b0, gyro}) - $signed({1'b0, gyro_offset});
            tsum = tilt_sum + rate;
            if (tsum > TILT_MAX)
                tsum = TILT_MAX;
            if (tsum < TILT_MIN)
                tsum = TILT_MIN;
            tilt_sum = tsum[TILT_W-1:0];
            delta = enc - last_encoder;
            last_encoder = enc;
            position_sum = position_sum + delta;
            acc = mul_wide(tilt_sum, gain_tilt) + mul_wide(rate, gain_rate)
                + mul_wide($signed(position_sum), gain_position)
                + mul_wide($signed(delta), gain_velocity);
            neg = acc[ACC_PRED_W-1];
            mag = neg ? -acc : acc;
            mag = mag >> FRAC_BITS_DEF;
            if (mag > SPEED_LIMIT)
            begin
                cmd.speed_percent = neg ? -SPEED_W'(SPEED_LIMIT) : SPEED_W'(SPEED_LIMIT);
                cmd.clamped = 1'b1;
            end
            else
            begin
                speed = mag[SPEED_W-1:0];
                cmd.speed_percent = neg ? -speed : speed;
                cmd.clamped = 1'b0;
            end
            expected_cmds.push_back(cmd);
        endfunction

        task check_command(logic signed [SPEED_W-1:0] speed, logic clamped);
            command_t exp_cmd;
            if (expected_cmds.size() == 0)
            begin
                report_mismatch($sformatf("unexpected command item speed=%0d clamped=%0b",
                                          speed, clamped));
                return;
            end
            exp_cmd = expected_cmds.pop_front();
            if (speed !== exp_cmd.speed_percent)
                report_mismatch($sformatf("speed_percent got %0d expected %0d",
                                          speed, exp_cmd.speed_percent));
            if (clamped !== exp_cmd.clamped)
                report_mismatch($sformatf("clamped got %0b expected %0b",
                                          clamped, exp_cmd.clamped));
        endtask
    endclass

    logic clk;
    logic rst_n;

    bsf_sample_if #(.GYRO_BITS(GYRO_BITS_DEF)) sample_ch();
    bsf_command_if command_ch();
    bsf_cfg_if     cfg_ch();

    balance_state_feedback_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .sample  (sample_ch),
        .command (command_ch)
    );

    command_scoreboard sb = new();

    bit no_idle;
    bit stall_req;
    int stall_left;
    logic [GYRO_BITS_DEF-1:0] cur_offset;
    logic [ENC_W-1:0]         enc_track;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // command side: check accepted items, random backpressure, long stall on request
    initial
    begin
        command_ch.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (command_ch.valid && command_ch.ready)
                sb.check_command(command_ch.speed_percent, command_ch.clamped);
            if (stall_req)
            begin
                stall_req = 0;
                stall_left = 80;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                command_ch.ready <= 1'b0;
            end
            else if (no_idle)
                command_ch.ready <= 1'b1;
            else
                command_ch.ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    task automatic send_sample(logic [GYRO_BITS_DEF-1:0] gyro, logic [ENC_W-1:0] enc);
        if (!no_idle && $urandom_range(0, 99) < 35)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.gyro_sample   <= gyro;
        sample_ch.encoder_count <= enc;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_sample(gyro, enc);
        enc_track = enc;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(logic [GYRO_BITS_DEF-1:0] offset, logic [GAIN_W-1:0] g_tilt,
                             logic [GAIN_W-1:0] g_rate, logic [GAIN_W-1:0] g_pos,
                             logic [GAIN_W-1:0] g_vel);
        write_reg(REG_GYRO_OFFSET, CFG_DATA_W'(offset) | ($urandom << GYRO_BITS_DEF));
        write_reg(REG_GAIN_TILT, g_tilt);
        write_reg(REG_GAIN_RATE, g_rate);
        write_reg(REG_GAIN_POSITION, g_pos);
        write_reg(REG_GAIN_VELOCITY, g_vel);
        // unused indexes must leave everything alone
        for (int i = int'(REG_GAIN_VELOCITY) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        cfg_ch.valid <= 1'b0;
        cur_offset = offset;
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        logic signed [GAIN_W-1:0] g;
        g = $urandom;
        return g >>> $urandom_range(6, 28);
    endfunction

    initial
    begin
        int g;
        rst_n                   <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.gyro_sample   <= '0;
        sample_ch.encoder_count <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= '0;
        cfg_ch.data             <= '0;
        no_idle    = 0;
        stall_req  = 0;
        cur_offset = GYRO_BITS_DEF'(GYRO_OFFSET_RST);
        enc_track  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains, gyro and encoder extremes, encoder wrap
        send_sample(10'd595, 32'd0);
        send_sample(10'd0, 32'h7FFF_FFFF);
        send_sample(10'd1023, 32'h8000_0000);
        send_sample(10'd595, 32'h7FFF_FFFF);
        send_sample(10'd600, 32'd0);
        send_sample(10'd590, -32'sd5);
        wait_idle();

        // rate gain of 100.5: exact 100.5 truncates without clamp
        configure(10'd512, 32'd0, 32'd6586368, 32'd0, 32'd0);
        send_sample(10'd513, $urandom);
        send_sample(10'd511, $urandom);
        send_sample(10'd514, $urandom);
        send_sample(10'd510, $urandom);
        send_sample(10'd512, $urandom);
        send_sample(10'd1023, $urandom);
        send_sample(10'd0, $urandom);
        wait_idle();

        configure(10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(10'd0, 32'h8000_0000);
        send_sample(10'd1023, 32'h7FFF_FFFF);
        send_sample(10'd1, 32'h7FFF_FFFE);
        wait_idle();

        configure(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(10'd1023, 32'h0000_0000);
        send_sample(10'd0, 32'hFFFF_FFFF);
        send_sample(10'd1022, 32'h0000_0001);
        wait_idle();

        configure(10'd595, 32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(10'd0, 32'h1234_5678);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            configure(ph == 1 ? 10'd0 : (ph == 4 ? 10'd1023 : GYRO_BITS_DEF'($urandom)),
                      rand_gain(), rand_gain(), rand_gain(), rand_gain());
            no_idle = (ph == 0);
            if (ph == 2)
                stall_req = 1;
            for (int n = 0; n < 70; n++)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    // balanced motion: gyro near offset, small encoder steps
                    g = int'(cur_offset) + $urandom_range(0, 16) - 8;
                    if (g < 0)
                        g = 0;
                    if (g > 1023)
                        g = 1023;
                    send_sample(GYRO_BITS_DEF'(g),
                                enc_track + ENC_W'($urandom_range(0, 40)) - ENC_W'(20));
                end
                else
                    send_sample(GYRO_BITS_DEF'($urandom), $urandom);
            end
            wait_idle();
            no_idle = 0;
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
